@@ design/lzwd_pkg.sv @@
// ----------------------------------------------------------------------------
// lzwd_pkg
// Shared types and constants for the LZ window decompressor: decoder phase
// codes, the command record from decoder to copy sequencer, field widths.
// ----------------------------------------------------------------------------
package lzwd_pkg;

   localparam int unsigned HISTORY_DEPTH_DEF = 64;
   localparam int unsigned BYTE_W            = 8;
   localparam int unsigned NIBBLE_W          = 4;
   localparam int unsigned HELD_W            = 2;
   // longest copy is 3 + 15 + 1 = 19, largest offset is 3 + 15 = 18
   localparam int unsigned LEN_W             = 5;
   localparam int unsigned OFF_W             = 5;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'b001,
      PH_ESC   = 3'b010,
      PH_THIRD = 3'b100
   } phase_type;

   typedef struct packed {
      logic                lit_valid;
      logic [BYTE_W-1:0]   lit_byte;
      logic                copy_valid;
      logic [LEN_W-1:0]    copy_len;
      logic [OFF_W-1:0]    copy_off;
   } cmd_type;

endpackage

@@ design/lz_window_decompressor_top.sv @@
// ----------------------------------------------------------------------------
// lz_window_decompressor_top
// LZ window decompressor: literal/escape decoding, a history ring memory and
// a copy sequencer replaying back-references one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
// Path: a literal passes the data stage and output registers to rsp_; the
//   first byte of a back-reference passes the copy counter, the registered
//   history read (with the data stage) and the output register.
// Throughput: one literal or escape byte per cycle while the output is not
//   stalled; a back-reference of length L (1..19) holds req_ off until the
//   single history read port has issued one read per copied byte.
// Reset: synchronous; clears the phase machine, escape value, ring pointer
//   and history valid bits (history reads as zero), no clearing pass.
// ----------------------------------------------------------------------------
module lz_window_decompressor_top #(
   parameter int unsigned HISTORY_DEPTH = lzwd_pkg::HISTORY_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   // configuration write channel
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_data,
   // compressed input
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   // decompressed output
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last
);
   import lzwd_pkg::*;

   localparam int unsigned AW = $clog2(HISTORY_DEPTH);

   cmd_type           cmd;
   logic              req_accept;

   // copy sequencer
   logic [LEN_W-1:0]  remain_ff, remain_in;
   logic [OFF_W-1:0]  off_ff, off_in;
   logic              issue;

   // data stage: one byte waiting for its history read or literal value
   logic              d_valid_ff, d_valid_in;
   logic              d_lit_ff, d_lit_in;
   logic [BYTE_W-1:0] d_byte_ff, d_byte_in;
   logic              d_last_ff, d_last_in;
   logic              d_adv;

   // ring pointer
   logic [AW-1:0]     newest_ff, newest_in;
   logic [AW-1:0]     wr_addr, rd_base, rd_addr;
   logic [AW:0]       rd_diff;
   logic [BYTE_W-1:0] rd_data, cur_byte;

   // output register
   logic              rsp_valid_ff;
   logic [BYTE_W-1:0] rsp_byte_ff;
   logic              rsp_last_ff;
   logic              out_free;

   // configuration must only be written while idle, which the block does not enforce: always take it
   assign csr_ready = 1'b1;

   // hold input while a copy is replaying or the data stage is blocked
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign d_adv      = d_valid_ff && out_free;
   assign req_stall  = (remain_ff != '0) || (d_valid_ff && !out_free);
   assign req_accept = req_valid && !req_stall;

   lzwd_decoder u_decoder (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_valid && csr_ready),
      .csr_data   (csr_data),
      .req_accept (req_accept),
      .req_byte   (req_in_byte),
      .cmd        (cmd)
   );

   // next write slot, wrapping at the history depth
   assign wr_addr = (newest_ff == AW'(HISTORY_DEPTH - 1)) ? '0 : newest_ff + AW'(1);

   // read address is taken relative to the newest byte at issue time; if the
   // data stage writes in this cycle, that byte is already the newest
   assign rd_base = d_adv ? wr_addr : newest_ff;
   always_comb begin
      rd_diff = {1'b0, rd_base} - (AW+1)'(off_ff);
      if ({1'b0, rd_base} < (AW+1)'(off_ff)) begin
         rd_diff = rd_diff + (AW+1)'(HISTORY_DEPTH);
      end
   end
   assign rd_addr = rd_diff[AW-1:0];

   // issue one read per copied byte when the data stage frees up
   assign issue = (remain_ff != '0) && (!d_valid_ff || d_adv);

   lzwd_hist_mem #(
      .DEPTH (HISTORY_DEPTH),
      .AW    (AW)
   ) u_hist_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (d_adv),
      .wr_addr (wr_addr),
      .wr_data (cur_byte),
      .rd_en   (issue),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign cur_byte = d_lit_ff ? d_byte_ff : rd_data;

   always_comb begin
      remain_in  = remain_ff;
      off_in     = off_ff;
      d_valid_in = d_valid_ff;
      d_lit_in   = d_lit_ff;
      d_byte_in  = d_byte_ff;
      d_last_in  = d_last_ff;
      newest_in  = d_adv ? wr_addr : newest_ff;

      if (cmd.copy_valid) begin
         // load a new back-reference; replay starts once the counter is loaded and the data stage is free
         remain_in = cmd.copy_len;
         off_in    = cmd.copy_off;
      end else if (issue) begin
         remain_in = remain_ff - LEN_W'(1);
      end

      if (issue) begin
         d_valid_in = 1'b1;
         d_lit_in   = 1'b0;
         d_last_in  = (remain_ff == LEN_W'(1));
      end else if (cmd.lit_valid) begin
         d_valid_in = 1'b1;
         d_lit_in   = 1'b1;
         d_byte_in  = cmd.lit_byte;
         d_last_in  = 1'b1;
      end else if (d_adv) begin
         d_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff  <= '0;
         d_valid_ff <= 1'b0;
         newest_ff  <= '0;
      end else begin
         remain_ff  <= remain_in;
         d_valid_ff <= d_valid_in;
         newest_ff  <= newest_in;
      end
   end

   always_ff @(posedge clock) begin
      off_ff    <= off_in;
      d_lit_ff  <= d_lit_in;
      d_byte_ff <= d_byte_in;
      d_last_ff <= d_last_in;
   end

   // output register: load on data stage advance, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (d_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (d_adv) begin
         rsp_byte_ff <= cur_byte;
         rsp_last_ff <= d_last_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_run_last = rsp_last_ff;

   // a pending copy must keep the input side closed
   a_copy_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (remain_ff != '0) |-> req_stall)
      else $error("input accepted during copy replay");

   // a blocked data stage keeps its byte
   a_dstage_holds: assert property (@(posedge clock) disable iff (reset)
      (d_valid_ff && !out_free) |=> d_valid_ff)
      else $error("data stage dropped a byte while blocked");

   // a new back-reference loads its full length into the counter
   a_copy_load: assert property (@(posedge clock) disable iff (reset)
      cmd.copy_valid |=> (remain_ff == $past(cmd.copy_len)))
      else $error("copy length not loaded");

   // every history write advances the ring pointer to the written slot
   a_ring_advance: assert property (@(posedge clock) disable iff (reset)
      d_adv |=> (newest_ff == $past(wr_addr)))
      else $error("ring pointer out of step with history writes");

endmodule

@@ design/lzwd_decoder.sv @@
// ----------------------------------------------------------------------------
// lzwd_decoder
// Escape register and token phase machine. Turns accepted stream bytes into
// literal or copy commands for the sequencer.
// ----------------------------------------------------------------------------
module lzwd_decoder (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [7:0]            csr_data,
   input  logic                  req_accept,
   input  logic [7:0]            req_byte,
   output lzwd_pkg::cmd_type     cmd
);
   import lzwd_pkg::*;

   phase_type           phase_ff, phase_in;
   logic [HELD_W-1:0]   held_len_ff, held_len_in;
   logic [HELD_W-1:0]   held_off_ff, held_off_in;
   logic [BYTE_W-1:0]   escape_ff;

   logic [NIBBLE_W-1:0] lo_nib, hi_nib;

   assign lo_nib = req_byte[NIBBLE_W-1:0];
   assign hi_nib = req_byte[BYTE_W-1:NIBBLE_W];

   always_comb begin
      phase_in    = phase_ff;
      held_len_in = held_len_ff;
      held_off_in = held_off_ff;
      cmd         = '0;
      if (req_accept) begin
         unique case (phase_ff)
            PH_ESC: begin
               phase_in = PH_IDLE;
               if (req_byte == '0) begin
                  cmd.lit_valid = 1'b1;
                  cmd.lit_byte  = escape_ff;
               end else if (lo_nib == '0) begin
                  // long form: hold the extra bits until the third byte
                  held_len_in = req_byte[NIBBLE_W+HELD_W-1:NIBBLE_W];
                  held_off_in = req_byte[BYTE_W-1:BYTE_W-HELD_W];
                  phase_in    = PH_THIRD;
               end else begin
                  cmd.copy_valid = 1'b1;
                  cmd.copy_len   = LEN_W'(lo_nib) + LEN_W'(1);
                  cmd.copy_off   = OFF_W'(hi_nib);
               end
            end
            PH_THIRD: begin
               phase_in       = PH_IDLE;
               cmd.copy_valid = 1'b1;
               cmd.copy_len   = LEN_W'(held_len_ff) + LEN_W'(lo_nib) + LEN_W'(1);
               cmd.copy_off   = OFF_W'(held_off_ff) + OFF_W'(hi_nib);
            end
            default: begin
               phase_in = PH_IDLE;
               if (req_byte == escape_ff) begin
                  phase_in = PH_ESC;
               end else begin
                  cmd.lit_valid = 1'b1;
                  cmd.lit_byte  = req_byte;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         held_len_ff <= '0;
         held_off_ff <= '0;
         escape_ff   <= '0;
      end else begin
         phase_ff    <= phase_in;
         held_len_ff <= held_len_in;
         held_off_ff <= held_off_in;
         if (csr_write) begin
            escape_ff <= csr_data;
         end
      end
   end

endmodule

@@ design/lzwd_hist_mem.sv @@
// ----------------------------------------------------------------------------
// lzwd_hist_mem
// History ring memory: one write and one registered read per cycle, per-entry
// valid bits so unwritten entries read as zero, write-to-read forwarding.
// ----------------------------------------------------------------------------
module lzwd_hist_mem #(
   parameter int unsigned DEPTH = lzwd_pkg::HISTORY_DEPTH_DEF,
   parameter int unsigned AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);
   import lzwd_pkg::*;

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0]  vld_ff;
   logic [BYTE_W-1:0] mem_q_ff;
   logic              hit_ff;
   logic              fwd_ff;
   logic [BYTE_W-1:0] fwd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         mem_q_ff <= mem[rd_addr];
      end
   end

   // read side flags and forwarded data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         hit_ff      <= vld_ff[rd_addr];
         fwd_ff      <= wr_en && (wr_addr == rd_addr);
         fwd_data_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   assign rd_data = fwd_ff ? fwd_data_ff : (hit_ff ? mem_q_ff : '0);

endmodule
